// ----- hdl/slps_pkg.sv -----
`timescale 1ns / 1ps

package slps_pkg;

   typedef enum logic [2:0] {
      MODE_STARTUP    = 3'd0,
      MODE_CONNECTING = 3'd1,
      MODE_CONNECTED  = 3'd2,
      MODE_FAILED     = 3'd3,
      MODE_OFF        = 3'd4,
      MODE_AP         = 3'd5,
      MODE_POWER_OFF  = 3'd6,
      MODE_IDLE       = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      CSR_SLOW_BLINK  = 2'd0,
      CSR_FAST_BLINK  = 2'd1,
      CSR_HOLD        = 2'd2,
      CSR_PASS_PERIOD = 2'd3
   } csr_index_type;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam int PERIOD_W   = 10;
   localparam int CMD_W      = 3;

   localparam logic [INTERVAL_W-1:0] SLOW_BLINK_RESET  = 16'd500;
   localparam logic [INTERVAL_W-1:0] FAST_BLINK_RESET  = 16'd100;
   localparam logic [INTERVAL_W-1:0] HOLD_RESET        = 16'd2000;
   localparam logic [PERIOD_W-1:0]   PASS_PERIOD_RESET = 10'd100;

   localparam int MSG_DEPTH_DEFAULT   = 16;
   localparam int DEFER_DEPTH_DEFAULT = 16;

   typedef struct packed {
      logic     has_cmd;
      mode_type cmd;
   } pass_word_type;

   typedef struct packed {
      logic push_a;
      logic push_b;
      logic pop;
   } fifo_ctl_type;

endpackage

// ----- hdl/slps_fifo.sv -----
`timescale 1ns / 1ps

module slps_fifo import slps_pkg::*; #(
   parameter int DEPTH = MSG_DEPTH_DEFAULT,
   localparam int PW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  fifo_ctl_type     ctl,
   input  logic [CMD_W-1:0] a_data,
   input  logic [CMD_W-1:0] b_data,
   output logic [CW-1:0]    count,
   output logic [CMD_W-1:0] head_data,
   output logic             busy
);

   logic [CMD_W-1:0] mem [DEPTH];
   logic [CMD_W-1:0] rd_ff;

   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             pend_ff, pend_in;
   logic [PW-1:0]    pend_addr_ff, pend_addr_in;
   logic [CMD_W-1:0] pend_data_ff, pend_data_in;

   logic             we;
   logic [PW-1:0]    wa;
   logic [CMD_W-1:0] wd;
   logic [PW-1:0]    tail_next;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p == PW'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      tail_next    = ptr_inc(tail_ff);
      we           = 1'b0;
      wa           = tail_ff;
      wd           = a_data;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      pend_data_in = pend_data_ff;
      priority if (pend_ff) begin
         we = 1'b1;
         wa = pend_addr_ff;
         wd = pend_data_ff;
      end else if (ctl.push_a) begin
         we = 1'b1;
         // second push in the same pass is held in the pending register and written in the next cycle
         if (ctl.push_b) begin
            pend_in      = 1'b1;
            pend_addr_in = tail_next;
            pend_data_in = b_data;
         end
      end else if (ctl.push_b) begin
         we = 1'b1;
         wd = b_data;
      end
      tail_in = tail_ff;
      if (ctl.push_a && ctl.push_b) begin
         tail_in = ptr_inc(tail_next);
      end else if (ctl.push_a || ctl.push_b) begin
         tail_in = tail_next;
      end
      head_in  = ctl.pop ? ptr_inc(head_ff) : head_ff;
      count_in = count_ff + CW'(ctl.push_a) + CW'(ctl.push_b) - CW'(ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
   end

   // head prefetch, write-first on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (we && (wa == head_in)) begin
         rd_ff <= wd;
      end else begin
         rd_ff <= mem[head_in];
      end
   end

   assign count     = count_ff;
   assign head_data = rd_ff;
   assign busy      = pend_ff;

endmodule

// ----- hdl/slps_front.sv -----
`timescale 1ns / 1ps

module slps_front import slps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_cmd_valid,
   input  logic [CMD_W-1:0] req_cmd,
   output logic             q_valid,
   output pass_word_type    q_word,
   input  logic             q_pop
);

   pass_word_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          accept;
   pass_word_type word_in;

   always_comb begin
      req_stall       = (count_ff == 2'd2);
      accept          = req_valid && !req_stall;
      word_in.has_cmd = req_cmd_valid;
      word_in.cmd     = mode_type'(req_cmd);
      q_valid         = (count_ff != 2'd0);
      q_word          = slot_ff[rd_ptr_ff];
      wr_ptr_in       = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in       = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in        = count_ff + 2'(accept) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= word_in;
      end
   end

endmodule

// ----- hdl/slps_engine.sv -----
`timescale 1ns / 1ps

module slps_engine import slps_pkg::*; #(
   parameter int MSG_DEPTH = MSG_DEPTH_DEFAULT,
   parameter int DEFER_DEPTH = DEFER_DEPTH_DEFAULT,
   localparam int MCW = $clog2(MSG_DEPTH + 1),
   localparam int DCW = $clog2(DEFER_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  q_valid,
   input  pass_word_type         q_word,
   output logic                  q_pop,
   output fifo_ctl_type          msg_ctl,
   output logic [CMD_W-1:0]      msg_a_data,
   output logic [CMD_W-1:0]      msg_b_data,
   input  logic [MCW-1:0]        msg_count,
   input  logic [CMD_W-1:0]      msg_head,
   input  logic                  msg_busy,
   output fifo_ctl_type          dfr_ctl,
   output logic [CMD_W-1:0]      dfr_data,
   input  logic [DCW-1:0]        dfr_count,
   input  logic [CMD_W-1:0]      dfr_head,
   input  logic                  dfr_busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_led_on,
   output logic [CMD_W-1:0]      rsp_mode,
   output logic                  rsp_cmd_dropped,
   output logic                  rsp_pass_deferred
);

   logic [INTERVAL_W-1:0] slow_ff, fast_ff, hold_ms_ff;
   logic [PERIOD_W-1:0]   period_ff;

   mode_type          mode_ff, mode_in;
   mode_type          prev_mode_ff, prev_mode_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [TIME_W-1:0] hold_start_ff, hold_start_in;
   logic [TIME_W-1:0] blink_start_ff, blink_start_in;
   logic              phase_ff, phase_in;
   logic              led_ff, led_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_led_ff;
   mode_type          rsp_mode_ff;
   logic              rsp_drop_ff;
   logic              rsp_defer_ff;

   logic                  out_free, go;
   logic                  msg_full, msg_full2, dfr_full;
   logic                  push_a, push_b, dfr_push, requeue;
   logic                  have_msg, deferred, drop, active;
   logic [MCW-1:0]        cnt1, cnt2;
   mode_type              msg, mode1, mode2;
   logic [TIME_W-1:0]     hold1, elapsed_blink, elapsed_hold;
   logic [INTERVAL_W-1:0] interval;
   logic                  blink_due, hold_due, led1, led2;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      go       = q_valid && out_free && !msg_busy && !dfr_busy;
      q_pop    = go;

      msg_full = (msg_count == MCW'(MSG_DEPTH));
      push_a   = go && q_word.has_cmd && !msg_full;
      drop     = go && q_word.has_cmd && msg_full;
      cnt1     = msg_count + MCW'(push_a);
      have_msg = go && (cnt1 != '0);
      msg      = (msg_count == '0) ? q_word.cmd : mode_type'(msg_head);

      deferred = have_msg && (mode_ff == MODE_CONNECTED);
      dfr_full = (dfr_count == DCW'(DEFER_DEPTH));
      dfr_push = deferred && !dfr_full;
      if (deferred && dfr_full) begin
         drop = 1'b1;
      end
      active = go && !deferred;

      // entry action of the new mode
      mode1 = mode_ff;
      hold1 = hold_start_ff;
      led1  = led_ff;
      if (have_msg && !deferred) begin
         mode1 = msg;
         unique case (msg)
            MODE_CONNECTED, MODE_FAILED, MODE_POWER_OFF: hold1 = time_ff;
            MODE_OFF: led1 = 1'b0;
            MODE_AP: led1 = 1'b1;
            default: ;
         endcase
      end

      // mode pattern
      elapsed_blink  = time_ff - blink_start_ff;
      elapsed_hold   = time_ff - hold1;
      interval       = (mode1 == MODE_POWER_OFF) ? fast_ff : slow_ff;
      blink_due      = elapsed_blink > {{(TIME_W-INTERVAL_W){1'b0}}, interval};
      hold_due       = elapsed_hold > {{(TIME_W-INTERVAL_W){1'b0}}, hold_ms_ff};
      mode2          = mode1;
      led2           = led1;
      blink_start_in = blink_start_ff;
      phase_in       = phase_ff;
      if (active) begin
         unique case (mode1)
            MODE_STARTUP, MODE_CONNECTING, MODE_POWER_OFF: begin
               if (blink_due) begin
                  blink_start_in = time_ff;
                  phase_in       = !phase_ff;
                  led2           = !phase_ff;
               end
            end
            MODE_CONNECTED, MODE_FAILED: begin
               if (hold_due) begin
                  led2  = 1'b0;
                  mode2 = MODE_IDLE;
               end
            end
            default: ;
         endcase
      end

      // entering idle brings back one deferred word
      requeue   = active && (prev_mode_ff != mode2) && (mode2 == MODE_IDLE)
                  && (dfr_count != '0);
      cnt2      = cnt1 - MCW'(have_msg);
      msg_full2 = (cnt2 == MCW'(MSG_DEPTH));
      push_b    = requeue && !msg_full2;
      if (requeue && msg_full2) begin
         drop = 1'b1;
      end

      prev_mode_in  = active ? mode2 : prev_mode_ff;
      time_in       = active ? time_ff + {{(TIME_W-PERIOD_W){1'b0}}, period_ff} : time_ff;
      mode_in       = mode2;
      hold_start_in = hold1;
      led_in        = led2;

      msg_ctl.push_a = push_a;
      msg_ctl.push_b = push_b;
      msg_ctl.pop    = have_msg;
      msg_a_data     = q_word.cmd;
      msg_b_data     = dfr_head;
      dfr_ctl.push_a = dfr_push;
      dfr_ctl.push_b = 1'b0;
      dfr_ctl.pop    = requeue;
      dfr_data       = msg;

      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_ff        <= SLOW_BLINK_RESET;
         fast_ff        <= FAST_BLINK_RESET;
         hold_ms_ff     <= HOLD_RESET;
         period_ff      <= PASS_PERIOD_RESET;
         mode_ff        <= MODE_IDLE;
         prev_mode_ff   <= MODE_IDLE;
         time_ff        <= '0;
         hold_start_ff  <= '0;
         blink_start_ff <= '0;
         phase_ff       <= 1'b0;
         led_ff         <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_addr))
               CSR_SLOW_BLINK:  slow_ff    <= csr_wdata;
               CSR_FAST_BLINK:  fast_ff    <= csr_wdata;
               CSR_HOLD:        hold_ms_ff <= csr_wdata;
               CSR_PASS_PERIOD: period_ff  <= csr_wdata[PERIOD_W-1:0];
            endcase
         end
         mode_ff        <= mode_in;
         prev_mode_ff   <= prev_mode_in;
         time_ff        <= time_in;
         hold_start_ff  <= hold_start_in;
         blink_start_ff <= blink_start_in;
         phase_ff       <= phase_in;
         led_ff         <= led_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_led_ff   <= led_in;
         rsp_mode_ff  <= mode_in;
         rsp_drop_ff  <= drop;
         rsp_defer_ff <= deferred;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_led_on        = rsp_led_ff;
   assign rsp_mode          = rsp_mode_ff;
   assign rsp_cmd_dropped   = rsp_drop_ff;
   assign rsp_pass_deferred = rsp_defer_ff;

endmodule

// ----- hdl/status_led_pattern_sequencer.sv -----
`timescale 1ns / 1ps

// channel  ports                                   handshake
// req      req_cmd_valid req_cmd                   req_valid / req_stall
// rsp      rsp_led_on rsp_mode rsp_cmd_dropped     rsp_valid / rsp_stall
//          rsp_pass_deferred
// csr      csr_addr csr_wdata                      csr_we
//
// one pass per cycle unless rsp_stall or a busy write port holds it; a word goes from req to rsp
// through the input queue and the result register; a pass that both stores a new command and
// brings back a deferred one makes the engine wait for its second write: the message memory has a single write port
// synchronous reset clears the queues and the mode state, no clearing pass
// rsp_stall holds the result register; the 2-word input queue then fills and raises req_stall

module status_led_pattern_sequencer import slps_pkg::*; #(
   parameter int MSG_DEPTH = MSG_DEPTH_DEFAULT,
   parameter int DEFER_DEPTH = DEFER_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd_valid,
   input  logic [CMD_W-1:0]      req_cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_led_on,
   output logic [CMD_W-1:0]      rsp_mode,
   output logic                  rsp_cmd_dropped,
   output logic                  rsp_pass_deferred
);

   localparam int MCW = $clog2(MSG_DEPTH + 1);
   localparam int DCW = $clog2(DEFER_DEPTH + 1);

   logic             q_valid, q_pop;
   pass_word_type    q_word;
   fifo_ctl_type     msg_ctl, dfr_ctl;
   logic [CMD_W-1:0] msg_a_data, msg_b_data, msg_head;
   logic [CMD_W-1:0] dfr_data, dfr_head;
   logic [MCW-1:0]   msg_count;
   logic [DCW-1:0]   dfr_count;
   logic             msg_busy, dfr_busy;

   slps_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd_valid (req_cmd_valid),
      .req_cmd       (req_cmd),
      .q_valid       (q_valid),
      .q_word        (q_word),
      .q_pop         (q_pop)
   );

   slps_fifo #(.DEPTH(MSG_DEPTH)) u_msg_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (msg_ctl),
      .a_data    (msg_a_data),
      .b_data    (msg_b_data),
      .count     (msg_count),
      .head_data (msg_head),
      .busy      (msg_busy)
   );

   slps_fifo #(.DEPTH(DEFER_DEPTH)) u_dfr_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dfr_ctl),
      .a_data    (dfr_data),
      .b_data    (dfr_data),
      .count     (dfr_count),
      .head_data (dfr_head),
      .busy      (dfr_busy)
   );

   slps_engine #(.MSG_DEPTH(MSG_DEPTH), .DEFER_DEPTH(DEFER_DEPTH)) u_engine (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .q_valid           (q_valid),
      .q_word            (q_word),
      .q_pop             (q_pop),
      .msg_ctl           (msg_ctl),
      .msg_a_data        (msg_a_data),
      .msg_b_data        (msg_b_data),
      .msg_count         (msg_count),
      .msg_head          (msg_head),
      .msg_busy          (msg_busy),
      .dfr_ctl           (dfr_ctl),
      .dfr_data          (dfr_data),
      .dfr_count         (dfr_count),
      .dfr_head          (dfr_head),
      .dfr_busy          (dfr_busy),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_led_on        (rsp_led_on),
      .rsp_mode          (rsp_mode),
      .rsp_cmd_dropped   (rsp_cmd_dropped),
      .rsp_pass_deferred (rsp_pass_deferred)
   );

`ifndef SYNTHESIS
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   a_defer_only_connected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pass_deferred |-> rsp_mode == MODE_CONNECTED)
      else $error("deferred pass outside connected mode");

   a_off_is_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode == MODE_OFF) |-> !rsp_led_on)
      else $error("led lit in off mode");

   a_single_late_write: assert property (@(posedge clock) disable iff (reset)
      msg_busy |=> !msg_busy)
      else $error("message write port held two cycles");
`endif

endmodule

// ----- tb/status_led_pattern_sequencer_checker.sv -----
`timescale 1ns / 1ps

module status_led_pattern_sequencer_checker import slps_pkg::*; #(
   parameter int MSG_DEPTH = MSG_DEPTH_DEFAULT,
   parameter int DEFER_DEPTH = DEFER_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_cmd_valid,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_led_on,
   input  logic [CMD_W-1:0]      rsp_mode,
   input  logic                  rsp_cmd_dropped,
   input  logic                  rsp_pass_deferred,
   output int                    error_count,
   output int                    pending_count,
   output int                    drop_count,
   output int                    defer_count
);

   localparam int MSG_Q = 0;
   localparam int DEFER_Q = 1;
   localparam int MAX_DEPTH = (MSG_DEPTH > DEFER_DEPTH) ? MSG_DEPTH : DEFER_DEPTH;

   typedef struct packed {
      logic             led_on;
      logic [CMD_W-1:0] mode;
      logic             dropped;
      logic             deferred;
   } pass_outcome_type;

   logic [INTERVAL_W-1:0] slow_ms;
   logic [INTERVAL_W-1:0] fast_ms;
   logic [INTERVAL_W-1:0] hold_len_ms;
   logic [PERIOD_W-1:0]   period_ms;

   mode_type          cur_mode;
   mode_type          last_mode;
   logic [TIME_W-1:0] now_ms;
   logic [TIME_W-1:0] hold_t0;
   logic [TIME_W-1:0] blink_t0;
   logic              blink_lvl;
   logic              led_lvl;

   logic [CMD_W-1:0] q_mem [2][MAX_DEPTH];
   int               q_head [2];
   int               q_count [2];

   pass_outcome_type pending_outcomes [$];
   int errors = 0;
   int drops = 0;
   int defers = 0;

   function automatic bit q_push(input int which, input logic [CMD_W-1:0] v);
      int depth;
      depth = (which == MSG_Q) ? MSG_DEPTH : DEFER_DEPTH;
      if (q_count[which] >= depth) return 1'b0;
      q_mem[which][(q_head[which] + q_count[which]) % depth] = v;
      q_count[which]++;
      return 1'b1;
   endfunction

   function automatic bit q_pop(input int which, output logic [CMD_W-1:0] v);
      int depth;
      depth = (which == MSG_Q) ? MSG_DEPTH : DEFER_DEPTH;
      if (q_count[which] == 0) return 1'b0;
      v = q_mem[which][q_head[which] % depth];
      q_head[which] = (q_head[which] + 1) % depth;
      q_count[which]--;
      return 1'b1;
   endfunction

   function automatic void blink_step(input logic [INTERVAL_W-1:0] interval);
      if (now_ms - blink_t0 > interval) begin
         blink_t0 = now_ms;
         blink_lvl = ~blink_lvl;
         led_lvl = blink_lvl;
      end
   endfunction

   function automatic pass_outcome_type led_pass_outcome(input logic cv,
                                                         input logic [CMD_W-1:0] c);
      pass_outcome_type r;
      logic [CMD_W-1:0] msg;
      logic dropped;
      logic deferred;
      dropped = 1'b0;
      deferred = 1'b0;
      if (cv) begin
         if (!q_push(MSG_Q, c)) dropped = 1'b1;
      end
      if (q_pop(MSG_Q, msg)) begin
         if (cur_mode == MODE_CONNECTED) begin
            if (!q_push(DEFER_Q, msg)) dropped = 1'b1;
            deferred = 1'b1;
         end else begin
            cur_mode = mode_type'(msg);
            case (cur_mode)
               MODE_CONNECTED, MODE_FAILED, MODE_POWER_OFF: hold_t0 = now_ms;
               MODE_OFF: led_lvl = 1'b0;
               MODE_AP: led_lvl = 1'b1;
               default: ;
            endcase
         end
      end
      if (!deferred) begin
         case (cur_mode)
            MODE_STARTUP, MODE_CONNECTING: blink_step(slow_ms);
            MODE_CONNECTED, MODE_FAILED: begin
               if (now_ms - hold_t0 > hold_len_ms) begin
                  led_lvl = 1'b0;
                  cur_mode = MODE_IDLE;
               end
            end
            MODE_POWER_OFF: blink_step(fast_ms);
            default: ;
         endcase
         if (last_mode != cur_mode) begin
            last_mode = cur_mode;
            if (cur_mode == MODE_IDLE) begin
               // one deferred command goes back to the message queue
               if (q_pop(DEFER_Q, msg)) begin
                  if (!q_push(MSG_Q, msg)) dropped = 1'b1;
               end
            end
         end
         now_ms = now_ms + period_ms;
      end
      r.led_on = led_lvl;
      r.mode = cur_mode;
      r.dropped = dropped;
      r.deferred = deferred;
      return r;
   endfunction

   always @(posedge clock) begin
      pass_outcome_type got;
      pass_outcome_type want;
      if (reset) begin
         slow_ms = SLOW_BLINK_RESET;
         fast_ms = FAST_BLINK_RESET;
         hold_len_ms = HOLD_RESET;
         period_ms = PASS_PERIOD_RESET;
         cur_mode = MODE_IDLE;
         last_mode = MODE_IDLE;
         now_ms = '0;
         hold_t0 = '0;
         blink_t0 = '0;
         blink_lvl = 1'b0;
         led_lvl = 1'b1;
         q_head = '{0, 0};
         q_count = '{0, 0};
         pending_outcomes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_SLOW_BLINK: slow_ms = csr_wdata[INTERVAL_W-1:0];
               CSR_FAST_BLINK: fast_ms = csr_wdata[INTERVAL_W-1:0];
               CSR_HOLD: hold_len_ms = csr_wdata[INTERVAL_W-1:0];
               CSR_PASS_PERIOD: period_ms = csr_wdata[PERIOD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_led_on, rsp_mode, rsp_cmd_dropped, rsp_pass_deferred};
            if (pending_outcomes.size() == 0) begin
               errors++;
               $error("result word with no pass outstanding");
            end else begin
               want = pending_outcomes.pop_front();
               if (got.led_on !== want.led_on) begin
                  errors++;
                  $error("led_on expected %0d actual %0d", want.led_on, got.led_on);
               end
               if (got.mode !== want.mode) begin
                  errors++;
                  $error("mode expected %0d actual %0d", want.mode, got.mode);
               end
               if (got.dropped !== want.dropped) begin
                  errors++;
                  $error("cmd_dropped expected %0d actual %0d", want.dropped, got.dropped);
               end
               if (got.deferred !== want.deferred) begin
                  errors++;
                  $error("pass_deferred expected %0d actual %0d", want.deferred,
                         got.deferred);
               end
               if (want.dropped) drops++;
               if (want.deferred) defers++;
            end
         end
         if (req_valid && !req_stall) begin
            pending_outcomes.insert(pending_outcomes.size(),
                                    led_pass_outcome(req_cmd_valid, req_cmd));
         end
      end
      error_count <= errors;
      pending_count <= pending_outcomes.size();
      drop_count <= drops;
      defer_count <= defers;
   end

endmodule

// ----- tb/status_led_pattern_sequencer_tb.sv -----
`timescale 1ns / 1ps

module status_led_pattern_sequencer_tb;

   import slps_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_PASSES = 115;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_cmd_valid = 1'b0;
   logic [CMD_W-1:0]      req_cmd = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_led_on;
   logic [CMD_W-1:0]      rsp_mode;
   logic                  rsp_cmd_dropped;
   logic                  rsp_pass_deferred;

   int error_count;
   int pending_count;
   int drop_count;
   int defer_count;

   int passes_sent = 0;
   int settings_done = 0;
   bit quiet = 1'b0;
   int idle_cycles = 0;
   int stall_left = 0;
   int stall_pct = 0;
   int rsp_epoch = 0;

   status_led_pattern_sequencer u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd_valid     (req_cmd_valid),
      .req_cmd           (req_cmd),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_led_on        (rsp_led_on),
      .rsp_mode          (rsp_mode),
      .rsp_cmd_dropped   (rsp_cmd_dropped),
      .rsp_pass_deferred (rsp_pass_deferred)
   );

   status_led_pattern_sequencer_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd_valid     (req_cmd_valid),
      .req_cmd           (req_cmd),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_led_on        (rsp_led_on),
      .rsp_mode          (rsp_mode),
      .rsp_cmd_dropped   (rsp_cmd_dropped),
      .rsp_pass_deferred (rsp_pass_deferred),
      .error_count       (error_count),
      .pending_count     (pending_count),
      .drop_count        (drop_count),
      .defer_count       (defer_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side back-pressure, its stall percentage redrawn periodically among 0, 5, 20 and 50
   always @(posedge clock) begin
      int r;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         stall_pct = 0;
         rsp_epoch = 0;
      end else begin
         rsp_epoch++;
         if (rsp_epoch % 300 == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 5;
               2: stall_pct = 20;
               default: stall_pct = 50;
            endcase
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 80) stall_left = $urandom_range(0, 1);
            else if (r < 97) stall_left = $urandom_range(2, 7);
            else stall_left = $urandom_range(19, 49);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_pass(input logic cv, input logic [CMD_W-1:0] c);
      int r;
      int gap;
      req_valid <= 1'b1;
      req_cmd_valid <= cv;
      req_cmd <= c;
      do @(posedge clock); while (req_stall);
      passes_sent++;
      gap = 0;
      if (!quiet) begin
         r = $urandom_range(0, 99);
         if (r < 60) gap = 0;
         else if (r < 90) gap = $urandom_range(1, 3);
         else if (r < 98) gap = $urandom_range(4, 12);
         else gap = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_setting(input logic [INTERVAL_W-1:0] slow,
                                input logic [INTERVAL_W-1:0] fast,
                                input logic [INTERVAL_W-1:0] hold,
                                input logic [PERIOD_W-1:0]   period);
      wait_drained();
      csr_we <= 1'b1;
      csr_addr <= CSR_SLOW_BLINK;
      csr_wdata <= slow;
      @(posedge clock);
      csr_addr <= CSR_FAST_BLINK;
      csr_wdata <= fast;
      @(posedge clock);
      csr_addr <= CSR_HOLD;
      csr_wdata <= hold;
      @(posedge clock);
      csr_addr <= CSR_PASS_PERIOD;
      csr_wdata <= CSR_DATA_W'(period);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_done++;
   endtask

   task automatic run_random(input int budget);
      int sent;
      int kind;
      int len;
      int tail;
      bit mix;
      logic [CMD_W-1:0] c;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(0, 99);
         len = $urandom_range(4, 24);
         quiet = ($urandom_range(0, 3) == 0);
         if (kind < 3) begin
            wait_drained();
         end else if (kind < 48) begin
            // enter a hold mode, pile commands behind it, then let the hold run out
            mix = 1'($urandom_range(0, 1));
            c = ($urandom_range(0, 3) == 0) ? MODE_FAILED : MODE_CONNECTED;
            send_pass(1'b1, c);
            for (int i = 0; i < len; i++) begin
               if (mix) c = (i % 2) ? MODE_IDLE : mode_type'($urandom_range(0, 6));
               else c = CMD_W'($urandom_range(0, 7));
               send_pass($urandom_range(0, 9) != 0, c);
            end
            tail = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                              : $urandom_range(0, 40);
            repeat (tail) send_pass(1'b0, CMD_W'($urandom_range(0, 7)));
            sent += 1 + len + tail;
            if (mix) begin
               // dense off/idle flips bring deferred words back while new ones arrive
               for (int i = 0; i < 30; i++) begin
                  send_pass(1'b1, (i % 2) ? MODE_IDLE : MODE_OFF);
               end
               sent += 30;
            end
         end else if (kind < 70) begin
            repeat (len) send_pass(1'b1, CMD_W'($urandom_range(0, 7)));
            sent += len;
         end else if (kind < 90) begin
            repeat (len) send_pass($urandom_range(0, 3) == 0, CMD_W'($urandom_range(0, 7)));
            sent += len;
         end else begin
            repeat (len) send_pass(1'($urandom_range(0, 1)), CMD_W'($urandom_range(0, 7)));
            sent += len;
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // a few passes on the reset settings
      send_pass(1'b0, MODE_IDLE);
      send_pass(1'b1, MODE_STARTUP);
      send_pass(1'b0, MODE_STARTUP);

      // short intervals so blink and hold show up within a few passes
      write_setting(16'd2, 16'd1, 16'd3, 10'd1);
      repeat (2) send_pass(1'b0, CMD_W'($urandom_range(0, 7)));
      send_pass(1'b1, MODE_CONNECTING);
      send_pass(1'b0, MODE_AP);
      send_pass(1'b1, MODE_POWER_OFF);
      repeat (2) send_pass(1'b0, MODE_OFF);
      send_pass(1'b1, MODE_OFF);
      send_pass(1'b1, MODE_AP);
      send_pass(1'b1, MODE_FAILED);
      repeat (4) send_pass(1'b0, MODE_POWER_OFF);
      send_pass(1'b1, MODE_CONNECTED);
      send_pass(1'b1, MODE_STARTUP);
      send_pass(1'b1, MODE_IDLE);
      send_pass(1'b1, MODE_AP);
      repeat (4) send_pass(1'b0, CMD_W'($urandom_range(0, 7)));
      send_pass(1'b1, MODE_IDLE);

      write_setting(SLOW_BLINK_RESET, FAST_BLINK_RESET, HOLD_RESET, PASS_PERIOD_RESET);
      run_random(PHASE_PASSES);
      write_setting(16'd1, 16'd1, 16'd1, 10'd1);
      run_random(PHASE_PASSES);
      write_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1000);
      run_random(PHASE_PASSES);
      // zero everything: time stands still
      write_setting(16'd0, 16'd0, 16'd0, 10'd0);
      run_random(60);
      write_setting(16'd3, 16'd1, 16'd12, 10'd1023);
      run_random(100);
      write_setting(16'd3, 16'd1, 16'd12, 10'd1);
      run_random(PHASE_PASSES);
      write_setting(16'd700, 16'd40, 16'd900, 10'd100);
      run_random(PHASE_PASSES);
      repeat (3) begin
         write_setting(INTERVAL_W'($urandom_range(1, 2000)),
                       INTERVAL_W'($urandom_range(1, 500)),
                       INTERVAL_W'($urandom_range(1, 4000)),
                       PERIOD_W'($urandom_range(50, 400)));
         run_random(PHASE_PASSES);
      end

      wait_drained();
      repeat (10) @(posedge clock);

      $display("covered %0d passes under %0d register settings", passes_sent, settings_done);
      $display("results with a lost command: %0d, deferring passes: %0d",
               drop_count, defer_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/slps_pkg.sv
hdl/slps_fifo.sv
hdl/slps_front.sv
hdl/slps_engine.sv
hdl/status_led_pattern_sequencer.sv
tb/status_led_pattern_sequencer_checker.sv
tb/status_led_pattern_sequencer_tb.sv
